// ----- rtl/jsu_pkg.sv -----
// ============================================================================
// jsu_pkg
// Shared types, character codes and helper functions for the JSON string
// unescaper: result kinds, the result group that one input item produces,
// hex digit decode and UTF-8 encode.
// ============================================================================
`default_nettype none

package jsu_pkg;

    // Result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_NOSTR = 2'd2;

    // Result group queue geometry
    localparam int GRP_SLOTS = 4;
    localparam int GRP_DEPTH = 4;
    localparam int GRP_PTR_W = 2;
    localparam int GRP_CNT_W = 3;

    // Text characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    // Control characters produced by escapes
    localparam logic [7:0] CTRL_BS  = 8'h08;
    localparam logic [7:0] CTRL_FF  = 8'h0C;
    localparam logic [7:0] CTRL_LF  = 8'h0A;
    localparam logic [7:0] CTRL_CR  = 8'h0D;
    localparam logic [7:0] CTRL_TAB = 8'h09;

    // UTF-8 lead and continuation marks
    localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF8_CONT  = 8'h80;
    localparam logic [15:0] UTF8_TWO_MIN   = 16'h0080;
    localparam logic [15:0] UTF8_THREE_MIN = 16'h0800;

    // Up to four results caused by one input item
    typedef struct packed {
        logic [GRP_PTR_W-1:0]            last_idx;
        logic [GRP_SLOTS-1:0][1:0]       kind;
        logic [GRP_SLOTS-1:0][7:0]       data;
    } group_t;

    // UTF-8 encoding of one code point: one to three bytes
    typedef struct packed {
        logic [1:0]      n_m1;
        logic [2:0][7:0] bytes;
    } utf8_t;

    // Hex digit value; anything that is not a hex digit counts as zero
    function automatic logic [3:0] hex_value(input logic [7:0] b);
        logic [3:0] v;
        v = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = b[3:0];
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            v = b[3:0] + 4'd9;
        end
        return v;
    endfunction

    // Encode a 16-bit code point as UTF-8
    function automatic utf8_t utf8_encode(input logic [15:0] cp);
        utf8_t e;
        e = '0;
        if (cp < UTF8_TWO_MIN) begin
            e.n_m1     = 2'd0;
            e.bytes[0] = cp[7:0];
        end else if (cp < UTF8_THREE_MIN) begin
            e.n_m1     = 2'd1;
            e.bytes[0] = UTF8_LEAD2 | {3'b000, cp[10:6]};
            e.bytes[1] = UTF8_CONT | {2'b00, cp[5:0]};
        end else begin
            e.n_m1     = 2'd2;
            e.bytes[0] = UTF8_LEAD3 | {4'b0000, cp[15:12]};
            e.bytes[1] = UTF8_CONT | {2'b00, cp[11:6]};
            e.bytes[2] = UTF8_CONT | {2'b00, cp[5:0]};
        end
        return e;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/jsu_decode.sv -----
// ============================================================================
// jsu_decode
// Parser state and single-pass decode: turns one accepted text byte into a
// group of up to four results and updates the string / escape / hex state.
// ============================================================================
`default_nettype none

module jsu_decode (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           take,
    input  wire logic [7:0]     in_byte,
    output logic                push,
    output jsu_pkg::group_t     grp
);
    import jsu_pkg::*;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_STR  = 2'd1;
    localparam logic [1:0] MODE_ESC  = 2'd2;
    localparam logic [1:0] MODE_HEX  = 2'd3;

    logic [1:0]  mode_reg, mode_next;
    logic [1:0]  hex_cnt_reg, hex_cnt_next;
    logic [15:0] cp_reg, cp_next;
    logic [15:0] cp_shift;
    utf8_t       enc;

    // Shift in the next hex digit; a NUL encodes what has been gathered
    assign cp_shift = {cp_reg[11:0], hex_value(in_byte)};
    assign enc      = utf8_encode((in_byte == CH_NUL) ? cp_reg : cp_shift);

    // Decode one byte
    always_comb
    begin
        mode_next    = mode_reg;
        hex_cnt_next = hex_cnt_reg;
        cp_next      = cp_reg;
        push         = 1'b0;
        grp          = '0;
        unique case (mode_reg)
            MODE_IDLE:
            begin
                if (in_byte == CH_QUOTE) begin
                    mode_next = MODE_STR;
                end else begin
                    push        = 1'b1;
                    grp.kind[0] = KIND_NOSTR;
                end
            end
            MODE_STR:
            begin
                if (in_byte == CH_NUL || in_byte == CH_QUOTE) begin
                    push        = 1'b1;
                    grp.kind[0] = KIND_END;
                    mode_next   = MODE_IDLE;
                end else if (in_byte == CH_BSLASH) begin
                    mode_next = MODE_ESC;
                end else begin
                    push        = 1'b1;
                    grp.data[0] = in_byte;
                end
            end
            MODE_ESC:
            begin
                mode_next = MODE_STR;
                push      = 1'b1;
                unique case (in_byte) inside
                    CH_NUL:
                    begin
                        grp.data[0]  = CH_BSLASH;
                        grp.kind[1]  = KIND_END;
                        grp.last_idx = 2'd1;
                        mode_next    = MODE_IDLE;
                    end
                    CH_QUOTE, CH_BSLASH, CH_SLASH: grp.data[0] = in_byte;
                    CH_B: grp.data[0] = CTRL_BS;
                    CH_F: grp.data[0] = CTRL_FF;
                    CH_N: grp.data[0] = CTRL_LF;
                    CH_R: grp.data[0] = CTRL_CR;
                    CH_T: grp.data[0] = CTRL_TAB;
                    CH_U:
                    begin
                        push         = 1'b0;
                        mode_next    = MODE_HEX;
                        hex_cnt_next = 2'd0;
                        cp_next      = 16'd0;
                    end
                    default: grp.data[0] = CH_BSLASH;
                endcase
            end
            MODE_HEX:
            begin
                grp.data[2:0] = enc.bytes;
                grp.last_idx  = enc.n_m1;
                if (in_byte == CH_NUL) begin
                    // End of text: flush the partial code point, then end
                    push                        = 1'b1;
                    grp.kind[enc.n_m1 + 2'd1]   = KIND_END;
                    grp.data[enc.n_m1 + 2'd1]   = 8'h00;
                    grp.last_idx                = enc.n_m1 + 2'd1;
                    mode_next                   = MODE_IDLE;
                    hex_cnt_next                = 2'd0;
                    cp_next                     = 16'd0;
                end else if (hex_cnt_reg == 2'd3) begin
                    push         = 1'b1;
                    mode_next    = MODE_STR;
                    hex_cnt_next = 2'd0;
                    cp_next      = 16'd0;
                end else begin
                    hex_cnt_next = hex_cnt_reg + 2'd1;
                    cp_next      = cp_shift;
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase
    end

    // Advance parser state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg    <= MODE_IDLE;
            hex_cnt_reg <= 2'd0;
            cp_reg      <= 16'd0;
        end else if (take) begin
            mode_reg    <= mode_next;
            hex_cnt_reg <= hex_cnt_next;
            cp_reg      <= cp_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/jsu_group_fifo.sv -----
// ============================================================================
// jsu_group_fifo
// Short queue of result groups between the decoder and the output
// serializer; absorbs multi-byte UTF-8 runs while input keeps flowing.
// ============================================================================
`default_nettype none

module jsu_group_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire jsu_pkg::group_t    push_grp,
    input  wire logic               pop,
    output jsu_pkg::group_t         head,
    output logic                    empty,
    output logic                    full
);
    import jsu_pkg::*;

    group_t                 mem [GRP_DEPTH];
    logic [GRP_PTR_W-1:0]   wr_ptr_reg;
    logic [GRP_PTR_W-1:0]   rd_ptr_reg;
    logic [GRP_CNT_W-1:0]   count_reg;
    logic                   do_push;
    logic                   do_pop;

    assign empty   = (count_reg == GRP_CNT_W'(0));
    assign full    = (count_reg == GRP_CNT_W'(GRP_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    // Write a group at the tail
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_grp;
        end
    end

    // Track pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + GRP_PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + GRP_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + GRP_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - GRP_CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/jsu_serializer.sv -----
// ============================================================================
// jsu_serializer
// Output register: holds the current result group and presents its results one
// item per cycle while not stalled, loading the next group as the last leaves.
// ============================================================================
`default_nettype none

module jsu_serializer (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire jsu_pkg::group_t    head,
    input  wire logic               empty,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              kind,
    output logic [7:0]              out_byte,
    output logic                    last
);
    import jsu_pkg::*;

    logic                   cur_valid_reg;
    group_t                 cur_reg;
    logic [GRP_PTR_W-1:0]   idx_reg;
    logic                   sent;
    logic                   done;

    assign out_valid = cur_valid_reg;
    assign kind      = cur_reg.kind[idx_reg];
    assign out_byte  = cur_reg.data[idx_reg];
    assign last      = (idx_reg == cur_reg.last_idx);

    assign sent = cur_valid_reg && !out_stall;
    assign done = sent && last;
    assign pop  = (!cur_valid_reg || done) && !empty;

    // Load the next group when the current one is finished
    always_ff @(posedge clk)
    begin
        if (pop) begin
            cur_reg <= head;
        end
    end

    // Advance through the results of the current group
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else if (pop) begin
            cur_valid_reg <= 1'b1;
            idx_reg       <= '0;
        end else if (done) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else if (sent) begin
            idx_reg <= idx_reg + GRP_PTR_W'(1);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/json_string_unescape_utf8_top.sv -----
// ============================================================================
// json_string_unescape_utf8_top
// JSON string unescaper with UTF-8 encoding of \u escapes. Takes one text
// byte per cycle whenever in_stall is low; in_stall rises only while the
// four-entry result group queue is full. Each byte is decoded in a single
// pass against the parser state and gives zero to four result items, which
// leave on the output channel one item per cycle while out_stall is low,
// with last marking the final item caused by that byte. A byte that gives a
// result, accepted while no other result is waiting or being sent, is
// written into the result group queue and then loaded into the serializer's
// output register, from which its first item shows on the output. Sustained
// input rate is one byte per cycle as long as results are taken at one per
// cycle and the text averages no more than one result per byte; a \u escape
// expanding to three bytes borrows output cycles that the queue covers.
// ============================================================================
`default_nettype none

module json_string_unescape_utf8_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [1:0]      kind,
    output logic [7:0]      out_byte,
    output logic            last
);
    import jsu_pkg::*;

    logic   take;
    logic   dec_push;
    group_t dec_grp;
    group_t head;
    logic   empty;
    logic   full;
    logic   pop;

    // Accept an item whenever the queue has room
    assign in_stall = full;
    assign take     = in_valid && !in_stall;

    jsu_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .in_byte (in_byte),
        .push    (dec_push),
        .grp     (dec_grp)
    );

    jsu_group_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (take && dec_push),
        .push_grp (dec_grp),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    jsu_serializer u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .out_byte  (out_byte),
        .last      (last)
    );

endmodule

`default_nettype wire

// ----- rtl/jsu_checker.sv -----
// ============================================================================
// jsu_checker
// Port-level checks on the result channel of the unescaper, bound to the
// top level.
// ============================================================================
`default_nettype none

module jsu_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [1:0] kind,
    input wire logic [7:0] out_byte,
    input wire logic       last
);
    import jsu_pkg::*;

    // Only the three defined kinds appear
    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind == KIND_DATA || kind == KIND_END || kind == KIND_NOSTR))
        else $error("illegal result kind");

    // Non-data results carry a zero byte
    a_nondata_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind != KIND_DATA) |-> (out_byte == 8'h00))
        else $error("non-data result with nonzero byte");

    // String end and not-a-string close their group
    a_nondata_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind != KIND_DATA) |-> last)
        else $error("non-data result not marked last");

    // Hold a stalled item
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(kind) && $stable(out_byte) && $stable(last)))
        else $error("stalled output item changed");

endmodule

bind json_string_unescape_utf8_top jsu_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .out_byte  (out_byte),
    .last      (last)
);

`default_nettype wire

// ----- tb/sv/tb_json_string_unescape_utf8_top.sv -----
// ============================================================================
// tb_json_string_unescape_utf8_top
// Self-checking bench for the JSON string unescaper. Text bytes go in through
// the valid/stall input channel. A scoreboard class tracks the parser state,
// predicts the decoded items for every accepted byte and compares each item
// taken from the output channel against the oldest prediction. A directed
// run covers the edge cases first. Random strings follow, with escapes,
// \u runs and broken endings, under three sender/receiver idle mixes.
// ============================================================================

import jsu_pkg::*;

typedef enum logic [1:0] {
    PS_IDLE,
    PS_STRING,
    PS_ESCAPE,
    PS_HEX
} parse_state_e;

typedef struct {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
} decoded_item_t;

// Track the parser and hold the decoded items still owed by the block
class unescape_scoreboard;
    parse_state_e  state;
    logic [1:0]    digits_taken;
    logic [15:0]   code_point;
    decoded_item_t owed_items[$];
    decoded_item_t byte_items[$];
    int            errors;

    function new();
        state        = PS_IDLE;
        digits_taken = 2'd0;
        code_point   = 16'h0000;
        errors       = 0;
    endfunction

    function void add_item(logic [1:0] k, logic [7:0] d);
        decoded_item_t it;
        it.kind = k;
        it.data = (k == KIND_DATA) ? d : 8'h00;
        it.last = 1'b0;
        byte_items.push_back(it);
    endfunction

    // Emit one code point as one, two or three UTF-8 bytes
    function void add_code_point(logic [15:0] c);
        if (c < UTF8_TWO_MIN)
        begin
            add_item(KIND_DATA, c[7:0]);
        end
        else if (c < UTF8_THREE_MIN)
        begin
            add_item(KIND_DATA, UTF8_LEAD2 | {3'b000, c[10:6]});
            add_item(KIND_DATA, UTF8_CONT | {2'b00, c[5:0]});
        end
        else
        begin
            add_item(KIND_DATA, UTF8_LEAD3 | {4'b0000, c[15:12]});
            add_item(KIND_DATA, UTF8_CONT | {2'b00, c[11:6]});
            add_item(KIND_DATA, UTF8_CONT | {2'b00, c[5:0]});
        end
    endfunction

    // Advance the parser by one accepted byte and queue what it yields
    function void note_byte(logic [7:0] b);
        logic [3:0] nib;
        byte_items.delete();
        case (state)
            PS_IDLE:
            begin
                if (b == CH_QUOTE)
                    state = PS_STRING;
                else
                    add_item(KIND_NOSTR, 8'h00);
            end
            PS_STRING:
            begin
                if (b == CH_NUL || b == CH_QUOTE)
                begin
                    add_item(KIND_END, 8'h00);
                    state = PS_IDLE;
                end
                else if (b == CH_BSLASH)
                    state = PS_ESCAPE;
                else
                    add_item(KIND_DATA, b);
            end
            PS_ESCAPE:
            begin
                state = PS_STRING;
                case (b)
                    CH_NUL:
                    begin
                        add_item(KIND_DATA, CH_BSLASH);
                        add_item(KIND_END, 8'h00);
                        state = PS_IDLE;
                    end
                    CH_QUOTE, CH_BSLASH, CH_SLASH: add_item(KIND_DATA, b);
                    CH_B: add_item(KIND_DATA, CTRL_BS);
                    CH_F: add_item(KIND_DATA, CTRL_FF);
                    CH_N: add_item(KIND_DATA, CTRL_LF);
                    CH_R: add_item(KIND_DATA, CTRL_CR);
                    CH_T: add_item(KIND_DATA, CTRL_TAB);
                    CH_U:
                    begin
                        state        = PS_HEX;
                        digits_taken = 2'd0;
                        code_point   = 16'h0000;
                    end
                    default: add_item(KIND_DATA, CH_BSLASH);
                endcase
            end
            default:
            begin
                if (b == CH_NUL)
                begin
                    // early end: encode the digits gathered so far
                    add_code_point(code_point);
                    add_item(KIND_END, 8'h00);
                    state        = PS_IDLE;
                    digits_taken = 2'd0;
                    code_point   = 16'h0000;
                end
                else
                begin
                    if (b >= 8'h30 && b <= 8'h39)
                        nib = 4'(b - 8'h30);
                    else if (b >= 8'h61 && b <= 8'h66)
                        nib = 4'(b - 8'h57);
                    else if (b >= 8'h41 && b <= 8'h46)
                        nib = 4'(b - 8'h37);
                    else
                        nib = 4'h0;
                    code_point = {code_point[11:0], nib};
                    if (digits_taken == 2'd3)
                    begin
                        add_code_point(code_point);
                        state        = PS_STRING;
                        digits_taken = 2'd0;
                        code_point   = 16'h0000;
                    end
                    else
                        digits_taken = digits_taken + 2'd1;
                end
            end
        endcase
        if (byte_items.size() > 0)
            byte_items[byte_items.size() - 1].last = 1'b1;
        foreach (byte_items[i])
            owed_items.push_back(byte_items[i]);
    endfunction

    // Compare one item from the output channel with the oldest prediction
    function void check_result(logic [1:0] k, logic [7:0] d, logic l);
        decoded_item_t want;
        if (owed_items.size() == 0)
        begin
            $error("unexpected item: kind %0d, out_byte 0x%02h, last %0d", k, d, l);
            errors++;
        end
        else
        begin
            want = owed_items.pop_front();
            if (k !== want.kind)
            begin
                $error("kind: expected %0d, actual %0d", want.kind, k);
                errors++;
            end
            if (d !== want.data)
            begin
                $error("out_byte: expected 0x%02h, actual 0x%02h", want.data, d);
                errors++;
            end
            if (l !== want.last)
            begin
                $error("last: expected %0d, actual %0d", want.last, l);
                errors++;
            end
        end
    endfunction

    function int owed();
        return owed_items.size();
    endfunction
endclass

module tb_json_string_unescape_utf8_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_TAIL     = 8;
    localparam int PHASE_ITEMS    = 100;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte   = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       last;

    int in_idle_pct  = 0;
    int out_idle_pct = 0;
    int bytes_sent   = 0;
    int stuck_cycles = 0;

    unescape_scoreboard sb = new();

    logic [7:0] simple_escapes [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B,
                                       CH_F, CH_N, CH_R, CH_T};

    logic [15:0] edge_code_points [6] = '{16'h0000, 16'h007F, 16'h0080,
                                         16'h07FF, 16'h0800, 16'hFFFF};

    // Edge cases: not-a-string bytes, pass-through extremes, escapes,
    // \u with mixed-case digits, NUL after backslash, NUL inside \u
    logic [7:0] directed_text [27] = '{
        8'hFF, CH_NUL, CH_QUOTE, 8'h01, 8'hFF,
        CH_BSLASH, CH_QUOTE, CH_BSLASH, CH_N, CH_BSLASH, 8'h71,
        CH_BSLASH, CH_U, 8'h46, 8'h66, 8'h66, 8'h46, CH_QUOTE,
        CH_QUOTE, CH_BSLASH, CH_NUL,
        CH_QUOTE, CH_BSLASH, CH_U, 8'h37, 8'h47, CH_NUL};

    json_string_unescape_utf8_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .out_byte  (out_byte),
        .last      (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Take items from the output channel and throttle it at random
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(kind, out_byte, last);
        out_stall <= rst_n && ($urandom_range(0, 99) < out_idle_pct);
    end

    // Abort when neither channel moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Offer one byte, idling first at random, and hold it until accepted
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < in_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    // Send one \u digit; now and then a non-hex byte that counts as zero
    task automatic send_hex_digit(input logic [3:0] nib);
        logic [7:0] b;
        if ($urandom_range(0, 9) == 0)
        begin
            do
                b = 8'($urandom_range(1, 255));
            while ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
                   (b >= 8'h61 && b <= 8'h66));
        end
        else if (nib < 4'd10)
            b = 8'h30 + 8'(nib);
        else
            b = ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
        send_byte(b);
    endtask

    function automatic logic [15:0] pick_code_point();
        case ($urandom_range(0, 7))
            0:       return edge_code_points[$urandom_range(0, 5)];
            1, 2:    return 16'($urandom_range(16'h0000, 16'h007F));
            3, 4:    return 16'($urandom_range(16'h0080, 16'h07FF));
            default: return 16'($urandom_range(16'h0800, 16'hFFFF));
        endcase
    endfunction

    // Send one quoted string with random content and a random ending
    task automatic send_string();
        int          segs;
        int          cut;
        logic [7:0]  b;
        logic [15:0] cp;
        send_byte(CH_QUOTE);
        segs = $urandom_range(0, 6);
        for (int i = 0; i < segs; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    do
                        b = 8'($urandom_range(1, 255));
                    while (b == CH_QUOTE || b == CH_BSLASH);
                    send_byte(b);
                end
                4, 5:
                begin
                    send_byte(CH_BSLASH);
                    send_byte(simple_escapes[$urandom_range(0, 7)]);
                end
                6:
                begin
                    do
                        b = 8'($urandom_range(1, 255));
                    while (b == CH_QUOTE || b == CH_BSLASH || b == CH_SLASH ||
                           b == CH_B || b == CH_F || b == CH_N || b == CH_R ||
                           b == CH_T || b == CH_U);
                    send_byte(CH_BSLASH);
                    send_byte(b);
                end
                default:
                begin
                    cp = pick_code_point();
                    send_byte(CH_BSLASH);
                    send_byte(CH_U);
                    for (int d = 3; d >= 0; d--)
                        send_hex_digit(cp[d*4 +: 4]);
                end
            endcase
        end
        // Close normally most of the time, else end the text mid-string
        case ($urandom_range(0, 9))
            7: send_byte(CH_NUL);
            8:
            begin
                send_byte(CH_BSLASH);
                send_byte(CH_NUL);
            end
            9:
            begin
                cp  = pick_code_point();
                cut = $urandom_range(0, 3);
                send_byte(CH_BSLASH);
                send_byte(CH_U);
                for (int d = 3; d > 3 - cut; d--)
                    send_hex_digit(cp[d*4 +: 4]);
                send_byte(CH_NUL);
            end
            default: send_byte(CH_QUOTE);
        endcase
    endtask

    // Stop sending until every owed item has come out, then let the pipe settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.owed() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    task automatic run_phase(input int in_pct, input int out_pct);
        int goal;
        logic [7:0] b;
        in_idle_pct  = in_pct;
        out_idle_pct = out_pct;
        goal         = bytes_sent + PHASE_ITEMS;
        while (bytes_sent < goal)
        begin
            if ($urandom_range(0, 9) < 2)
            begin
                // noise between strings: anything but an opening quote
                repeat ($urandom_range(1, 3))
                begin
                    do
                        b = 8'($urandom_range(0, 255));
                    while (b == CH_QUOTE);
                    send_byte(b);
                end
            end
            else
                send_string();
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        in_idle_pct  = 23;
        out_idle_pct = 51;
        foreach (directed_text[i])
            send_byte(directed_text[i]);
        wait_drained();

        run_phase(23, 51);
        run_phase(51, 23);
        run_phase(0, 0);

        if (sb.errors == 0 && sb.owed() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
